/* rtl/rma_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rma_pkg
// Shared sizes, beat types and control groups of the ring moving average.
// ----------------------------------------------------------------------------
package rma_pkg;

    localparam int WINDOW      = 16;
    localparam int SAMPLE_BITS = 24;

    localparam int IDX_BITS   = $clog2(WINDOW);
    localparam int COUNT_BITS = $clog2(WINDOW + 1);
    localparam int SUM_BITS   = SAMPLE_BITS + $clog2(WINDOW);
    localparam int CNT_BITS   = $clog2(SUM_BITS);

    // Command codes carried in the cmd field of an input beat.
    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic                          cmd;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] average;
        logic [COUNT_BITS-1:0]         samples_used;
    } t_out_item;

    typedef struct packed {
        logic                rd_en;
        logic                wr_en;
        logic                clr;
        logic [IDX_BITS-1:0] addr;
    } t_ring_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

/* rtl/ring_moving_average.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_moving_average
// Boxcar moving average over the last WINDOW samples, kept in a ring memory.
// ----------------------------------------------------------------------------
// A push beat reads the entry it replaces from the registered ring memory, then
// writes the new sample, updates the running sum and starts a bit-serial
// divider. The state machine waits in ST_DIV for the divider's registered
// done flag, then ST_HOLD moves the quotient into the output register once
// that register is free. No new beat is accepted until the push has passed
// through ST_READ, ST_DIV and ST_HOLD back to ST_IDLE; a clear beat gives no
// result. The
// result sits in an output register, so the next beat can be taken while it
// waits. Reset and clear empty the ring at once through per-entry valid bits;
// there is no clearing pass.
module ring_moving_average
    import rma_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_HOLD = 4'b1000
    } t_state;

    t_state                        r_state, n_state;
    logic signed [SUM_BITS-1:0]    r_sum, n_sum;
    logic [IDX_BITS-1:0]           r_idx, n_idx;
    logic                          r_full, n_full;
    logic signed [SAMPLE_BITS-1:0] r_sample, n_sample;
    logic [COUNT_BITS-1:0]         r_count, n_count;
    logic                          r_out_valid, n_out_valid;
    t_out_item                     r_out, n_out;

    t_ring_ctl                     w_ring_ctl;
    logic signed [SAMPLE_BITS-1:0] w_old;
    logic                          w_div_start;
    t_div_stat                     w_div_stat;
    logic signed [SAMPLE_BITS-1:0] w_quotient;
    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_wrap;
    logic signed [SUM_BITS-1:0]    w_new_sum;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_wrap     = (r_idx == IDX_BITS'(WINDOW - 1));
    assign w_new_sum  = r_sum
                      - {{(SUM_BITS - SAMPLE_BITS){w_old[SAMPLE_BITS-1]}}, w_old}
                      + {{(SUM_BITS - SAMPLE_BITS){r_sample[SAMPLE_BITS-1]}}, r_sample};

    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_idx       = r_idx;
        n_full      = r_full;
        n_sample    = r_sample;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_div_start = 1'b0;

        w_ring_ctl       = '0;
        w_ring_ctl.addr  = r_idx;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_item.cmd == CMD_CLEAR) begin
                        w_ring_ctl.clr = 1'b1;
                        n_sum          = '0;
                        n_idx          = '0;
                        n_full         = 1'b0;
                    end else begin
                        w_ring_ctl.rd_en = 1'b1;
                        n_sample         = i_in_item.sample;
                        n_state          = ST_READ;
                    end
                end
            end
            ST_READ: begin
                w_ring_ctl.wr_en = 1'b1;
                w_div_start      = 1'b1;
                n_sum            = w_new_sum;
                n_idx            = w_wrap ? '0 : r_idx + IDX_BITS'(1);
                n_full           = r_full || w_wrap;
                n_count          = (r_full || w_wrap) ? COUNT_BITS'(WINDOW)
                                                      : COUNT_BITS'(r_idx) + COUNT_BITS'(1);
                n_state          = ST_DIV;
            end
            ST_DIV: begin
                if (w_div_stat.done) begin
                    n_state = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    n_out_valid             = 1'b1;
                    n_out.average           = w_quotient;
                    n_out.samples_used      = r_count;
                    n_state                 = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_idx       <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_idx       <= n_idx;
            r_full      <= n_full;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample <= n_sample;
        r_count  <= n_count;
        r_out    <= n_out;
    end

    rma_ring u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ring_ctl),
        .i_wr_data (r_sample),
        .o_rd_data (w_old)
    );

    rma_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_new_sum),
        .i_divisor  (n_count),
        .o_stat     (w_div_stat),
        .o_quotient (w_quotient)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    a_push_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in_item.cmd == CMD_PUSH |=> r_state == ST_READ)
        else $error("push beat did not start a ring read");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in_item.cmd == CMD_CLEAR
        |=> r_sum == '0 && r_idx == '0 && !r_full && r_state == ST_IDLE)
        else $error("clear beat left filter state behind");

    a_div_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_READ |=> w_div_stat.busy)
        else $error("divider not started after ring read");

    a_hold_idle_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_HOLD |-> !w_div_stat.busy)
        else $error("result taken while divider still busy");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.samples_used != '0
                        && r_out.samples_used <= COUNT_BITS'(WINDOW))
        else $error("samples_used out of range");

endmodule

/* rtl/rma_ring.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rma_ring
// Sample ring: a single-port synchronous memory with one valid bit per entry.
// ----------------------------------------------------------------------------
module rma_ring
    import rma_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_ring_ctl                     i_ctl,
    input  logic signed [SAMPLE_BITS-1:0] i_wr_data,
    output logic signed [SAMPLE_BITS-1:0] o_rd_data
);

    logic signed [SAMPLE_BITS-1:0] r_mem [WINDOW];
    logic signed [SAMPLE_BITS-1:0] r_rd_data;
    logic [WINDOW-1:0]             r_vld;
    logic                          r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_ctl.addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_ctl.addr];
        end
    end

    // Entries never written since reset or the last clear read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_vld[i_ctl.addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_vld <= r_vld[i_ctl.addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

/* rtl/rma_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rma_div
// Bit-serial restoring divider, one quotient bit per cycle, truncating
// toward zero.
// ----------------------------------------------------------------------------
module rma_div
    import rma_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [SUM_BITS-1:0]    i_dividend,
    input  logic [COUNT_BITS-1:0]         i_divisor,
    output t_div_stat                     o_stat,
    output logic signed [SAMPLE_BITS-1:0] o_quotient
);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_BITS-1:0]   r_cnt;
    logic [SUM_BITS-1:0]   r_q;
    logic [COUNT_BITS-1:0] r_rem;
    logic [COUNT_BITS-1:0] r_div;
    logic                  r_neg;

    logic [SUM_BITS-1:0]   w_mag;
    logic [COUNT_BITS:0]   w_trial;
    logic [COUNT_BITS:0]   w_diff;
    logic                  w_ge;
    logic [SUM_BITS-1:0]   w_signed_q;

    assign w_mag   = i_dividend[SUM_BITS-1] ? (~i_dividend + SUM_BITS'(1)) : i_dividend;
    assign w_trial = {r_rem, r_q[SUM_BITS-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // The dividend magnitude shifts out of the top of r_q while the
    // quotient bits shift in at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= w_mag;
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_dividend[SUM_BITS-1];
            r_cnt <= CNT_BITS'(SUM_BITS - 1);
        end else if (r_busy) begin
            r_q   <= {r_q[SUM_BITS-2:0], w_ge};
            r_rem <= w_ge ? w_diff[COUNT_BITS-1:0] : w_trial[COUNT_BITS-1:0];
            r_cnt <= r_cnt - CNT_BITS'(1);
        end
    end

    assign w_signed_q  = r_neg ? (SUM_BITS'(0) - r_q) : r_q;
    assign o_quotient  = w_signed_q[SAMPLE_BITS-1:0];
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule
